[sv/sorted_key_offset_leaf_defines.svh]
// Assertion macros for the leaf checker.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef SORTED_KEY_OFFSET_LEAF_DEFINES_SVH
`define SORTED_KEY_OFFSET_LEAF_DEFINES_SVH

// Same-cycle implication.
`define SKOL_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SKOL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/skol_pkg.sv]
// ----------------------------------------------------------------------------
// skol_pkg
// Shared types, codes and defaults for the sorted key/offset leaf.
// ----------------------------------------------------------------------------
package skol_pkg;

    localparam int LEAF_CAPACITY_DEF = 64;
    localparam int KEY_W             = 32;
    localparam int OFFSET_W          = 64;
    localparam int ENTRY_W           = KEY_W + OFFSET_W;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic                        operation;
        logic signed [KEY_W-1:0]     key;
        logic        [OFFSET_W-1:0]  rec_offset;
    } in_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFFSET_W-1:0] found_offset;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic start_ins;    // capture item, point at top of table
        logic start_srch;   // capture item, point at entry 0
        logic set_full;     // result: insert dropped
        logic ins_scan;     // walk down, shifting entries up
        logic srch_scan;    // walk up, comparing keys
        logic emit;         // move result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic done;
    } stat_t;

endpackage

[sv/skol_ram.sv]
// ----------------------------------------------------------------------------
// skol_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/skol_ctrl.sv]
// ----------------------------------------------------------------------------
// skol_ctrl
// Sequencer for the leaf: takes one beat, runs the insert or search walk in
// the datapath, or drops an insert on a full leaf, then hands the result to the output register.
// ----------------------------------------------------------------------------
module skol_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            operation,
    output logic            out_valid,
    input  logic            out_ready,
    input  skol_pkg::stat_t stat,
    output skol_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == skol_pkg::OP_SEARCH)
                    begin
                        cmd.start_srch = 1'b1;
                        state_next     = S_SRCH;
                    end
                    else if (stat.full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.start_ins = 1'b1;
                        state_next    = S_INS;
                    end
                end
            end
            S_INS:
            begin
                cmd.ins_scan = 1'b1;
                if (stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_SRCH:
            begin
                cmd.srch_scan = 1'b1;
                if (stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/skol_datapath.sv]
// ----------------------------------------------------------------------------
// skol_datapath
// Entry table in RAM, walk index, entry count and result registers.
// Insert walks down from the top moving entries up one slot; search walks up.
// ----------------------------------------------------------------------------
module skol_datapath #(
    parameter int LEAF_CAPACITY = skol_pkg::LEAF_CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  skol_pkg::in_t   in_data,
    input  skol_pkg::cmd_t  cmd,
    output skol_pkg::stat_t stat,
    output skol_pkg::out_t  out_data
);

    localparam int IW = (LEAF_CAPACITY > 1) ? $clog2(LEAF_CAPACITY) : 1;
    localparam int CW = $clog2(LEAF_CAPACITY + 1);

    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [CW-1:0]                      idx_reg;
    logic [CW-1:0]                      idx_next;
    logic                               pend_reg;
    logic                               pend_next;
    logic [IW-1:0]                      pend_addr_reg;
    logic [IW-1:0]                      pend_addr_next;

    logic signed [skol_pkg::KEY_W-1:0]  key_reg;
    logic [skol_pkg::OFFSET_W-1:0]      off_reg;
    skol_pkg::out_t                     res_reg;
    skol_pkg::out_t                     res_next;
    skol_pkg::out_t                     out_reg;

    logic                               rd_en;
    logic [IW-1:0]                      rd_addr;
    logic [skol_pkg::ENTRY_W-1:0]       rd_data;
    logic                               wr_en;
    logic [IW-1:0]                      wr_addr;
    logic [skol_pkg::ENTRY_W-1:0]       wr_data;

    logic signed [skol_pkg::KEY_W-1:0]  rd_key;
    logic [skol_pkg::OFFSET_W-1:0]      rd_off;
    logic [CW-1:0]                      idx_m1;
    logic                               done;

    skol_ram #(
        .WIDTH (skol_pkg::ENTRY_W),
        .DEPTH (LEAF_CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key = $signed(rd_data[skol_pkg::ENTRY_W-1 -: skol_pkg::KEY_W]);
    assign rd_off = rd_data[skol_pkg::OFFSET_W-1:0];
    assign idx_m1 = idx_reg - CW'(1);

    assign stat.full = (count_reg == CW'(LEAF_CAPACITY));
    assign stat.done = done;
    assign out_data  = out_reg;

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_m1[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg + IW'(1);
        wr_data        = {key_reg, off_reg};
        done           = 1'b0;

        if (cmd.start_ins)
        begin
            idx_next  = count_reg;
            pend_next = 1'b0;
        end
        else if (cmd.start_srch)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
        end
        else if (cmd.set_full)
        begin
            res_next.status       = skol_pkg::ST_FULL;
            res_next.found_offset = '1;
        end
        else if (cmd.ins_scan)
        begin
            // read the next lower entry while the previous one is placed
            rd_en          = (idx_reg != '0);
            pend_next      = rd_en;
            pend_addr_next = idx_m1[IW-1:0];
            if (rd_en)
            begin
                idx_next = idx_m1;
            end
            if (pend_reg)
            begin
                wr_en = 1'b1;
                if (rd_key < key_reg)
                begin
                    done = 1'b1;
                end
                else
                begin
                    wr_data = rd_data;
                end
            end
            else if (idx_reg == '0)
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                done    = 1'b1;
            end
            if (done)
            begin
                count_next            = count_reg + CW'(1);
                res_next.status       = skol_pkg::ST_INSERTED;
                res_next.found_offset = '1;
            end
        end
        else if (cmd.srch_scan)
        begin
            rd_en     = (idx_reg < count_reg);
            rd_addr   = idx_reg[IW-1:0];
            pend_next = rd_en;
            if (rd_en)
            begin
                idx_next = idx_reg + CW'(1);
            end
            if (pend_reg && (rd_key == key_reg))
            begin
                done                  = 1'b1;
                res_next.status       = skol_pkg::ST_FOUND;
                res_next.found_offset = rd_off;
            end
            else if (!pend_reg && !rd_en)
            begin
                done                  = 1'b1;
                res_next.status       = skol_pkg::ST_NOTFOUND;
                res_next.found_offset = '1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_ins || cmd.start_srch)
        begin
            key_reg <= in_data.key;
            off_reg <= in_data.rec_offset;
        end
        res_reg <= res_next;
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

[sv/sorted_key_offset_leaf.sv]
// ----------------------------------------------------------------------------
// sorted_key_offset_leaf
// One B+ tree leaf: sorted signed keys with record offsets, insert and search.
// ----------------------------------------------------------------------------
//   in channel  (in_valid/in_ready/in_data): operation, key, rec_offset.
//   out channel (out_valid/out_ready/out_data): status, found_offset.
//   Every input beat gives exactly one output beat, in order; one item at a
//   time, in_ready is high only while the sequencer is idle.
//   Insert walks down from the top entry, one entry per cycle through the
//   single RAM read port, moving each key not below the new one up a slot.
//   An insert on a full leaf is dropped without a walk. Search walks up from
//   entry 0, stopping at the first equal key; a miss reads every entry.
//   in_ready returns with the result beat, so the next item is not taken
//   before the result of the last one is shown.
//   Reset empties the leaf (entry count zero); RAM contents are not cleared.
//   If out_ready is low while a beat sits in the output register, that beat
//   holds; the finished result waits in the sequencer, no input is taken till it moves.
// ----------------------------------------------------------------------------
module sorted_key_offset_leaf #(
    parameter int LEAF_CAPACITY = skol_pkg::LEAF_CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  skol_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output skol_pkg::out_t out_data
);

    skol_pkg::cmd_t  cmd;
    skol_pkg::stat_t stat;

    skol_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (in_data.operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    skol_datapath #(
        .LEAF_CAPACITY (LEAF_CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

[sv/skol_checker.sv]
// ----------------------------------------------------------------------------
// skol_checker
// Port-level checks for the leaf, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_key_offset_leaf_defines.svh"

module skol_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input skol_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input skol_pkg::out_t out_data
);

    // a stalled output beat holds its payload
    `SKOL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")

    // offset is all ones unless the result is a hit
    `SKOL_ASSERT_NOW(a_miss_ones, out_valid && (out_data.status != skol_pkg::ST_FOUND), out_data.found_offset == '1, "non-hit result with offset not all ones")

    // one item at a time: busy right after an accepted beat
    `SKOL_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "input taken while an item is in flight")

    // a new result appears only as the sequencer goes idle
    `SKOL_ASSERT_NOW(a_emit_idle, $rose(out_valid), in_ready, "result issued while sequencer busy")

endmodule

bind sorted_key_offset_leaf skol_checker u_skol_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[tb/tb_sorted_key_offset_leaf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_offset_leaf
// Self-checking bench for the sorted key/offset leaf. A short table of
// directed beats covers the empty leaf, extreme keys and offsets, and
// duplicates. Random inserts and searches then fill the leaf and keep going
// once it is full. Each result beat is checked against the table's expected
// result or a local model of the sorted table. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_sorted_key_offset_leaf;

    localparam int LEAF_CAP     = skol_pkg::LEAF_CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_MAX   = 10;

    localparam logic [skol_pkg::OFFSET_W-1:0]     NO_OFFSET = '1;
    localparam logic signed [skol_pkg::KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;
    localparam logic signed [skol_pkg::KEY_W-1:0] KEY_MAX   = 32'sh7fff_ffff;

    typedef struct {
        skol_pkg::in_t  item;
        bit             typed;
        skol_pkg::out_t result;
    } stim_row_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    skol_pkg::in_t  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    skol_pkg::out_t out_data;

    // local copy of the leaf contents
    logic signed [skol_pkg::KEY_W-1:0] leaf_key [LEAF_CAP];
    logic [skol_pkg::OFFSET_W-1:0]     leaf_off [LEAF_CAP];
    int                                leaf_used = 0;

    skol_pkg::out_t pending_results [$];
    stim_row_t      directed_rows [$];
    skol_pkg::out_t oldest_result;

    int fail_count  = 0;
    int idle_cycles = 0;
    int n_inserted  = 0;
    int n_dropped   = 0;
    int n_hits      = 0;
    int n_misses    = 0;
    bit send_burst  = 1'b0;
    bit recv_burst  = 1'b0;

    sorted_key_offset_leaf #(
        .LEAF_CAPACITY(LEAF_CAP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Insert at the first key not below the new one, search for the first
    // equal key; updates the local leaf copy.
    function automatic skol_pkg::out_t leaf_apply(input skol_pkg::in_t item);
        skol_pkg::out_t                    res;
        logic signed [skol_pkg::KEY_W-1:0] k;
        int                                pos;
        int                                i;
        k                = item.key;
        res.status       = skol_pkg::ST_NOTFOUND;
        res.found_offset = NO_OFFSET;
        if (item.operation == skol_pkg::OP_INSERT)
        begin
            if (leaf_used >= LEAF_CAP)
            begin
                res.status = skol_pkg::ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < leaf_used && leaf_key[pos] < k)
                    pos++;
                for (i = leaf_used; i > pos; i--)
                begin
                    leaf_key[i] = leaf_key[i-1];
                    leaf_off[i] = leaf_off[i-1];
                end
                leaf_key[pos] = k;
                leaf_off[pos] = item.rec_offset;
                leaf_used++;
                res.status = skol_pkg::ST_INSERTED;
            end
        end
        else
        begin
            for (i = 0; i < leaf_used && res.status != skol_pkg::ST_FOUND; i++)
            begin
                if (leaf_key[i] == k)
                begin
                    res.status       = skol_pkg::ST_FOUND;
                    res.found_offset = leaf_off[i];
                end
            end
        end
        return res;
    endfunction

    // Mix of extremes, a narrow band for duplicates, and full-range keys.
    function automatic logic signed [skol_pkg::KEY_W-1:0] draw_key();
        case ($urandom_range(0, 7))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2, 3:    return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_row(input logic op,
                                    input logic signed [skol_pkg::KEY_W-1:0] key,
                                    input logic [skol_pkg::OFFSET_W-1:0] off,
                                    input bit typed, input logic [1:0] st,
                                    input logic [skol_pkg::OFFSET_W-1:0] res_off);
        stim_row_t row;
        row.item.operation      = op;
        row.item.key            = key;
        row.item.rec_offset     = off;
        row.typed               = typed;
        row.result.status       = st;
        row.result.found_offset = res_off;
        directed_rows.push_back(row);
    endfunction

    task automatic drive_item(input skol_pkg::in_t item, input bit typed,
                              input skol_pkg::out_t typed_res);
        int             gap;
        skol_pkg::out_t model_res;
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        model_res = leaf_apply(item);
        pending_results.push_back(typed ? typed_res : model_res);
    endtask

    initial
    begin : stim_proc
        skol_pkg::in_t  item;
        skol_pkg::out_t no_result;
        int             idx;
        int             insert_pct;
        no_result = '0;

        // empty leaf, then extremes
        add_row(skol_pkg::OP_SEARCH, 0, '0, 1'b1, skol_pkg::ST_NOTFOUND, NO_OFFSET);
        add_row(skol_pkg::OP_INSERT, 0, '0, 1'b1, skol_pkg::ST_INSERTED, NO_OFFSET);
        add_row(skol_pkg::OP_INSERT, KEY_MIN, '1, 1'b1, skol_pkg::ST_INSERTED, NO_OFFSET);
        add_row(skol_pkg::OP_INSERT, KEY_MAX, 64'h0123_4567_89ab_cdef, 1'b1,
                skol_pkg::ST_INSERTED, NO_OFFSET);
        add_row(skol_pkg::OP_SEARCH, KEY_MIN, '0, 1'b1, skol_pkg::ST_FOUND, NO_OFFSET);
        add_row(skol_pkg::OP_SEARCH, KEY_MAX, '1, 1'b1, skol_pkg::ST_FOUND,
                64'h0123_4567_89ab_cdef);
        add_row(skol_pkg::OP_SEARCH, 0, '0, 1'b1, skol_pkg::ST_FOUND, '0);
        add_row(skol_pkg::OP_SEARCH, -1, '0, 1'b1, skol_pkg::ST_NOTFOUND, NO_OFFSET);
        // duplicates: newest copy must win
        add_row(skol_pkg::OP_INSERT, 0, 64'h5555_5555_5555_5555, 1'b1,
                skol_pkg::ST_INSERTED, NO_OFFSET);
        add_row(skol_pkg::OP_SEARCH, 0, '0, 1'b0, skol_pkg::ST_FOUND, '0);
        add_row(skol_pkg::OP_INSERT, 0, 64'haaaa_aaaa_aaaa_aaaa, 1'b1,
                skol_pkg::ST_INSERTED, NO_OFFSET);
        add_row(skol_pkg::OP_SEARCH, 0, '0, 1'b0, skol_pkg::ST_FOUND, '0);
        add_row(skol_pkg::OP_INSERT, KEY_MIN, 64'd1, 1'b1, skol_pkg::ST_INSERTED, NO_OFFSET);
        add_row(skol_pkg::OP_SEARCH, KEY_MIN, '0, 1'b0, skol_pkg::ST_FOUND, '0);
        add_row(skol_pkg::OP_INSERT, -1, 64'hfedc_ba98_7654_3210, 1'b1,
                skol_pkg::ST_INSERTED, NO_OFFSET);
        add_row(skol_pkg::OP_INSERT, 1, 64'h8000_0000_0000_0001, 1'b1,
                skol_pkg::ST_INSERTED, NO_OFFSET);
        add_row(skol_pkg::OP_SEARCH, -1, '0, 1'b0, skol_pkg::ST_FOUND, '0);
        // offset field is ignored on search
        add_row(skol_pkg::OP_SEARCH, 1, '1, 1'b0, skol_pkg::ST_FOUND, '0);
        add_row(skol_pkg::OP_SEARCH, 2, '0, 1'b0, skol_pkg::ST_NOTFOUND, '0);
        add_row(skol_pkg::OP_INSERT, KEY_MAX, '0, 1'b1, skol_pkg::ST_INSERTED, NO_OFFSET);
        add_row(skol_pkg::OP_SEARCH, KEY_MAX, '0, 1'b0, skol_pkg::ST_FOUND, '0);
        add_row(skol_pkg::OP_SEARCH, KEY_MAX - 1, '0, 1'b0, skol_pkg::ST_NOTFOUND, '0);
        add_row(skol_pkg::OP_SEARCH, KEY_MIN + 1, '0, 1'b0, skol_pkg::ST_NOTFOUND, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            drive_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].result);

        // fill the leaf with searches mixed in, then hammer the full leaf
        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            send_burst      = ((idx / 40) % 4 == 3);
            item.rec_offset = {$urandom, $urandom};
            insert_pct      = (leaf_used < LEAF_CAP) ? 60 : 25;
            if ($urandom_range(0, 99) < insert_pct)
            begin
                item.operation = skol_pkg::OP_INSERT;
                item.key       = draw_key();
            end
            else
            begin
                item.operation = skol_pkg::OP_SEARCH;
                if (leaf_used > 0 && $urandom_range(0, 9) < 7)
                    item.key = leaf_key[$urandom_range(0, leaf_used - 1)];
                else
                    item.key = draw_key();
            end
            drive_item(item, 1'b0, no_result);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d inserts, %0d dropped on a full leaf,",
                 n_inserted, n_dropped);
        $display("%0d search hits, %0d misses; leaf held %0d entries; %0d check failures",
                 n_hits, n_misses, leaf_used, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : recv_proc
        int gap;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // result beat checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            case (out_data.status)
                skol_pkg::ST_INSERTED: n_inserted++;
                skol_pkg::ST_FULL:     n_dropped++;
                skol_pkg::ST_FOUND:    n_hits++;
                default:               n_misses++;
            endcase
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("ERROR: unexpected result beat status=%0d offset=%h",
                             out_data.status, out_data.found_offset);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (out_data.status !== oldest_result.status ||
                    out_data.found_offset !== oldest_result.found_offset)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("ERROR: expected status=%0d offset=%h, got %0d %h",
                                 oldest_result.status, oldest_result.found_offset,
                                 out_data.status, out_data.found_offset);
                end
            end
        end
    end

    // watchdog: no beat on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[filelist.f]
+incdir+sv
sv/skol_pkg.sv
sv/skol_ram.sv
sv/skol_ctrl.sv
sv/skol_datapath.sv
sv/sorted_key_offset_leaf.sv
sv/skol_checker.sv
tb/tb_sorted_key_offset_leaf.sv
